// ----- rtl/sld_pkg.sv -----
// ---------------------------------------------------------------------------
// sld_pkg
// Shared types, register codes and the header scan for the sync/length
// deframer.
// ---------------------------------------------------------------------------
package sld_pkg;

  // Discard counter width; the result port shows the low 32 bits
  localparam int COUNT_WIDTH = 32;
  localparam int TOTAL_WIDTH = 32;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_LIMIT = 3'd4;

  // Register reset values
  localparam logic [7:0] RST_SYNC_FIRST   = 8'hA5;
  localparam logic [7:0] RST_SYNC_SECOND  = 8'h5A;
  localparam logic [7:0] RST_MIN_LENGTH   = 8'd1;
  localparam logic [7:0] RST_MAX_LENGTH   = 8'd255;
  localparam logic [7:0] RST_ACCEPT_LIMIT = 8'd255;

  // Frame phase codes
  localparam logic PH_HUNT    = 1'b0;
  localparam logic PH_PAYLOAD = 1'b1;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] min_length;
    logic [7:0] max_length;
    logic [7:0] accept_limit;
  } cfg_t;

  // One result transaction
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       frame_last;
    logic [7:0] frame_length;
  } res_t;

  // Outcome of one header scan step
  typedef struct packed {
    logic       start;    // valid length found, frame begins
    logic [7:0] length;
    logic [1:0] fill;
    logic [7:0] win0;
    logic [7:0] win1;
    logic [1:0] disc;     // bytes thrown away by this step
  } hunt_t;

  // Append one byte to the header window and scan it. Each unsettled pass
  // removes at least one byte, so two passes always settle; a third is a spare.
  function automatic hunt_t hunt_step(logic [7:0] h0, logic [7:0] h1,
                                      logic [1:0] fill, logic [7:0] b, cfg_t c);
    logic [7:0] w [3];
    logic [1:0] n;
    logic [1:0] disc;
    logic       done;
    logic       hit;
    logic       pos;
    logic       keep;
    hunt_t      r;
    w[0] = h0;
    w[1] = h1;
    w[2] = 8'd0;
    n    = (fill > 2'd2) ? 2'd0 : fill;
    w[n] = b;
    n    = n + 2'd1;
    disc = 2'd0;
    done = 1'b0;
    r    = '0;
    for (int p = 0; p < 3; p++) begin
      if (!done) begin
        hit = 1'b0;
        pos = 1'b0;
        // lowest matching position wins
        if (n == 2'd3 && w[1] == c.sync_first && w[2] == c.sync_second) begin
          hit = 1'b1;
          pos = 1'b1;
        end
        if (n >= 2'd2 && w[0] == c.sync_first && w[1] == c.sync_second) begin
          hit = 1'b1;
          pos = 1'b0;
        end
        if (!hit) begin
          // no pair: drop all but a trailing first sync byte
          keep = (w[n - 2'd1] == c.sync_first);
          disc = disc + (n - {1'b0, keep});
          if (keep) begin
            w[0] = w[n - 2'd1];
          end
          n    = {1'b0, keep};
          done = 1'b1;
        end else begin
          if (pos) begin
            disc = disc + 2'd1;
            w[0] = w[1];
            w[1] = w[2];
            n    = 2'd2;
          end
          if (n < 2'd3) begin
            done = 1'b1;
          end else if (w[2] < c.min_length || w[2] > c.max_length) begin
            // bad length: drop one byte and rescan the rest
            disc = disc + 2'd1;
            w[0] = w[1];
            w[1] = w[2];
            n    = 2'd2;
          end else begin
            r.start  = 1'b1;
            r.length = w[2];
            n        = 2'd0;
            done     = 1'b1;
          end
        end
      end
    end
    r.fill = n;
    r.win0 = (n > 2'd0) ? w[0] : 8'd0;
    r.win1 = (n > 2'd1) ? w[1] : 8'd0;
    r.disc = disc;
    return r;
  endfunction

endpackage

// ----- rtl/sld_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// sld_cfg_regs
// Configuration register bank: sync pair, length window and accept limit.
// ---------------------------------------------------------------------------
module sld_cfg_regs import sld_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write; unknown indexes are ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SYNC_FIRST:   cfg_d.sync_first   = cfg_data_i;
        REG_SYNC_SECOND:  cfg_d.sync_second  = cfg_data_i;
        REG_MIN_LENGTH:   cfg_d.min_length   = cfg_data_i;
        REG_MAX_LENGTH:   cfg_d.max_length   = cfg_data_i;
        REG_ACCEPT_LIMIT: cfg_d.accept_limit = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first   <= RST_SYNC_FIRST;
      cfg_q.sync_second  <= RST_SYNC_SECOND;
      cfg_q.min_length   <= RST_MIN_LENGTH;
      cfg_q.max_length   <= RST_MAX_LENGTH;
      cfg_q.accept_limit <= RST_ACCEPT_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/sld_frame_fsm.sv -----
// ---------------------------------------------------------------------------
// sld_frame_fsm
// Frame state: header hunt, payload countdown and discard counter. Takes one
// byte per step and produces that byte's result.
// ---------------------------------------------------------------------------
module sld_frame_fsm import sld_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [7:0]             byte_i,
  input  cfg_t                   cfg_i,
  output res_t                   res_o,
  output logic [COUNT_WIDTH-1:0] discard_o
);

  logic                   phase_q, phase_d;
  logic [7:0]             win0_q, win0_d;
  logic [7:0]             win1_q, win1_d;
  logic [1:0]             fill_q, fill_d;
  logic [7:0]             left_q, left_d;
  logic [7:0]             len_q, len_d;
  logic                   supp_q, supp_d;
  logic [COUNT_WIDTH-1:0] disc_q, disc_d;
  hunt_t                  hunt;

  assign hunt = hunt_step(win0_q, win1_q, fill_q, byte_i, cfg_i);

  // Next state and result for the byte in the input register
  always_comb begin
    phase_d = phase_q;
    win0_d  = win0_q;
    win1_d  = win1_q;
    fill_d  = fill_q;
    left_d  = left_q;
    len_d   = len_q;
    supp_d  = supp_q;
    disc_d  = disc_q;
    res_o   = '0;
    if (phase_q == PH_PAYLOAD && left_q != 8'd0) begin
      // payload byte, never searched for sync
      if (!supp_q) begin
        res_o.payload_valid = 1'b1;
        res_o.payload_byte  = byte_i;
        res_o.frame_last    = (left_q == 8'd1);
        res_o.frame_length  = len_q;
      end
      left_d = left_q - 8'd1;
      if (left_q == 8'd1) begin
        phase_d = PH_HUNT;
        fill_d  = 2'd0;
        win0_d  = 8'd0;
        win1_d  = 8'd0;
      end
    end else begin
      phase_d = PH_HUNT;
      fill_d  = hunt.fill;
      win0_d  = hunt.win0;
      win1_d  = hunt.win1;
      disc_d  = disc_q + COUNT_WIDTH'(hunt.disc);
      if (hunt.start) begin
        len_d  = hunt.length;
        left_d = hunt.length;
        supp_d = (hunt.length > cfg_i.accept_limit);
        if (hunt.length != 8'd0) begin
          phase_d = PH_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      win0_q  <= '0;
      win1_q  <= '0;
      fill_q  <= '0;
      left_q  <= '0;
      len_q   <= '0;
      supp_q  <= 1'b0;
      disc_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      win0_q  <= win0_d;
      win1_q  <= win1_d;
      fill_q  <= fill_d;
      left_q  <= left_d;
      len_q   <= len_d;
      supp_q  <= supp_d;
      disc_q  <= disc_d;
    end
  end

  assign discard_o = disc_d;

endmodule

// ----- rtl/sync_length_deframer.sv -----
// ---------------------------------------------------------------------------
// sync_length_deframer
// Recovers sync-pair / length-prefixed frames from a received byte stream.
// ---------------------------------------------------------------------------
// Every accepted byte produces exactly one result transaction, via the input
// register and the header scan into the result register. One byte is taken
// every cycle unless the result side stalls; the header scan and frame state
// update between those two registers set that rate. Payload bytes of frames
// within accept_limit come out as they arrive, marked with frame_last on the
// final one; all other results carry zeros in the payload fields and only
// update discard_total. The user writes configuration through a plain write
// port only with no transaction in flight; the block does not enforce this.
module sync_length_deframer import sld_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 payload_valid_o,
  output logic [7:0]           payload_byte_o,
  output logic                 frame_last_o,
  output logic [7:0]           frame_length_o,
  output logic [31:0]          discard_total_o
);

  cfg_t                   cfg;
  res_t                   res;
  logic [COUNT_WIDTH-1:0] discard;
  logic                   in_vld_q;
  logic [7:0]             in_byte_q;
  logic                   out_vld_q;
  res_t                   out_res_q;
  logic [TOTAL_WIDTH-1:0] out_total_q;
  logic                   step;

  sld_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Byte moves from input register to result register when the result slot
  // is free or being drained this cycle
  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  sld_frame_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (in_byte_q),
    .cfg_i     (cfg),
    .res_o     (res),
    .discard_o (discard)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q   <= res;
      out_total_q <= TOTAL_WIDTH'(discard);
    end
  end

  assign out_valid_o     = out_vld_q;
  assign payload_valid_o = out_res_q.payload_valid;
  assign payload_byte_o  = out_res_q.payload_byte;
  assign frame_last_o    = out_res_q.frame_last;
  assign frame_length_o  = out_res_q.frame_length;
  assign discard_total_o = out_total_q;

endmodule

// ----- rtl/sld_checker.sv -----
// ---------------------------------------------------------------------------
// sld_checker
// Port-level checks on the deframer's result channel.
// ---------------------------------------------------------------------------
module sld_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        payload_valid_o,
  input logic [7:0]  payload_byte_o,
  input logic        frame_last_o,
  input logic [7:0]  frame_length_o,
  input logic [31:0] discard_total_o
);

  // A stalled result transaction holds its counter value
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(discard_total_o))
    else $error("result changed while stalled");

  // Non-payload results carry zero payload fields
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !payload_valid_o |->
      payload_byte_o == 8'd0 && !frame_last_o && frame_length_o == 8'd0)
    else $error("payload fields set without payload_valid");

  // A delivered payload byte belongs to a frame of nonzero length
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && payload_valid_o |-> frame_length_o != 8'd0)
    else $error("payload byte with zero frame length");

  // Payload bytes never add to the discard count
  a_payload_no_disc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i ##1 out_valid_o && payload_valid_o && !frame_last_o
      && out_ready_i |=> out_valid_o |-> discard_total_o == $past(discard_total_o))
    else $error("discard count moved across a payload byte");

endmodule

bind sync_length_deframer sld_checker u_sld_checker (.*);

// ----- tb/deframer_monitor.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// deframer_monitor
// Watches the register port and both channels of the sync/length deframer,
// keeps its own copy of the frame state, predicts one result per received
// byte and compares every returned result field by field.
// ---------------------------------------------------------------------------
module deframer_monitor import sld_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [7:0]             cfg_data_i,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [7:0]             rx_byte_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic                   payload_valid_i,
  input  logic [7:0]             payload_byte_i,
  input  logic                   frame_last_i,
  input  logic [7:0]             frame_length_i,
  input  logic [31:0]            discard_total_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     delivered_o,
  output int                     frames_o,
  output logic [TOTAL_WIDTH-1:0] discards_o
);

  localparam int MAX_REPORTS = 20;

  // One predicted result transaction
  typedef struct packed {
    res_t                   fields;
    logic [TOTAL_WIDTH-1:0] total;
  } expected_t;

  // Register copy and frame state
  cfg_t                   regs;
  logic                   phase;
  logic [7:0]             hdr_win [2];
  logic [1:0]             hdr_fill;
  logic [7:0]             bytes_left;
  logic [7:0]             frame_len;
  logic                   suppress;
  logic [COUNT_WIDTH-1:0] dropped;
  expected_t              results_q [$];

  task automatic add_dropped(input int n);
    dropped = dropped + COUNT_WIDTH'(n);
  endtask

  // Append a byte to the held header bytes and scan; each rescan drops a byte
  task automatic scan_header(input logic [7:0] b);
    logic [7:0] w [3];
    int         n;
    int         i;
    int         k;
    int         keep;
    bit         found;
    bit         busy;
    w[0] = hdr_win[0];
    w[1] = hdr_win[1];
    w[2] = 8'd0;
    n    = (hdr_fill > 2'd2) ? 0 : int'(hdr_fill);
    w[n] = b;
    n++;
    busy = 1'b1;
    while (busy) begin
      found = 1'b0;
      i     = 0;
      while (!found && i + 1 < n) begin
        if (w[i] == regs.sync_first && w[i + 1] == regs.sync_second) found = 1'b1;
        else i++;
      end
      if (!found) begin
        // no pair: keep only a trailing first sync byte
        keep = (w[n - 1] == regs.sync_first) ? 1 : 0;
        add_dropped(n - keep);
        if (keep != 0) w[0] = w[n - 1];
        n    = keep;
        busy = 1'b0;
      end else begin
        if (i > 0) begin
          add_dropped(i);
          for (k = 0; k + i < n; k++) w[k] = w[k + i];
          n = n - i;
        end
        if (n < 3) begin
          busy = 1'b0;
        end else if (w[2] < regs.min_length || w[2] > regs.max_length) begin
          // bad length: lose the first byte and look again
          add_dropped(1);
          w[0] = w[1];
          w[1] = w[2];
          n    = 2;
        end else begin
          frame_len  = w[2];
          bytes_left = w[2];
          suppress   = (w[2] > regs.accept_limit);
          if (w[2] != 8'd0) phase = PH_PAYLOAD;
          n    = 0;
          busy = 1'b0;
        end
      end
    end
    hdr_fill   = 2'(n);
    hdr_win[0] = (n > 0) ? w[0] : 8'd0;
    hdr_win[1] = (n > 1) ? w[1] : 8'd0;
  endtask

  // Expected result for one received byte
  task automatic predict_result(input logic [7:0] b, output expected_t e);
    e = '0;
    if (phase == PH_PAYLOAD && bytes_left != 8'd0) begin
      if (!suppress) begin
        e.fields.payload_valid = 1'b1;
        e.fields.payload_byte  = b;
        e.fields.frame_last    = (bytes_left == 8'd1);
        e.fields.frame_length  = frame_len;
      end
      if (bytes_left == 8'd1) begin
        phase      = PH_HUNT;
        hdr_fill   = 2'd0;
        hdr_win[0] = 8'd0;
        hdr_win[1] = 8'd0;
      end
      bytes_left = bytes_left - 8'd1;
    end else begin
      phase = PH_HUNT;
      scan_header(b);
    end
    e.total = dropped[TOTAL_WIDTH-1:0];
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count_o++;
      if (fail_count_o <= MAX_REPORTS)
        $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Track writes, predict on accepted bytes, compare accepted results
  always @(posedge clk_i or negedge rst_ni) begin : monitor_seq
    expected_t e;
    if (!rst_ni) begin
      regs.sync_first   = RST_SYNC_FIRST;
      regs.sync_second  = RST_SYNC_SECOND;
      regs.min_length   = RST_MIN_LENGTH;
      regs.max_length   = RST_MAX_LENGTH;
      regs.accept_limit = RST_ACCEPT_LIMIT;
      phase             = PH_HUNT;
      hdr_win[0]        = 8'd0;
      hdr_win[1]        = 8'd0;
      hdr_fill          = 2'd0;
      bytes_left        = 8'd0;
      frame_len         = 8'd0;
      suppress          = 1'b0;
      dropped           = '0;
      results_q.delete();
      fail_count_o      = 0;
      pending_o         = 0;
      delivered_o       = 0;
      frames_o          = 0;
      discards_o        = '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SYNC_FIRST:   regs.sync_first   = cfg_data_i;
          REG_SYNC_SECOND:  regs.sync_second  = cfg_data_i;
          REG_MIN_LENGTH:   regs.min_length   = cfg_data_i;
          REG_MAX_LENGTH:   regs.max_length   = cfg_data_i;
          REG_ACCEPT_LIMIT: regs.accept_limit = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        predict_result(rx_byte_i, e);
        results_q.push_back(e);
      end
      if (out_valid_i && out_ready_i) begin
        if (results_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MAX_REPORTS)
            $display("%0t: result transaction expected none, actual payload %0h",
                     $time, payload_byte_i);
        end else begin
          e = results_q.pop_front();
          check_field("payload_valid", 32'(e.fields.payload_valid), 32'(payload_valid_i));
          check_field("payload_byte", 32'(e.fields.payload_byte), 32'(payload_byte_i));
          check_field("frame_last", 32'(e.fields.frame_last), 32'(frame_last_i));
          check_field("frame_length", 32'(e.fields.frame_length), 32'(frame_length_i));
          check_field("discard_total", 32'(e.total), discard_total_i);
          if (e.fields.payload_valid) delivered_o++;
          if (e.fields.frame_last) frames_o++;
          discards_o = e.total;
        end
      end
      pending_o = results_q.size();
    end
  end

endmodule

// ----- tb/sync_length_deframer_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sync_length_deframer_tb
// Feeds the deframer a byte stream of well-formed frames, broken headers and
// noise under several register settings, with random gaps and stalls on
// both channels; the monitor beside the block checks every result.
// ---------------------------------------------------------------------------
module sync_length_deframer_tb import sld_pkg::*;;

  localparam int IDLE_PCT      = 37;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 400000;
  // index with no register behind it; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data  = 8'd0;
  logic                 in_valid  = 1'b0;
  logic [7:0]           rx_byte   = 8'd0;
  logic                 out_ready = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 payload_valid;
  logic [7:0]           payload_byte;
  logic                 frame_last;
  logic [7:0]           frame_length;
  logic [31:0]          discard_total;

  int                     fail_count;
  int                     pending;
  int                     delivered;
  int                     frames;
  logic [TOTAL_WIDTH-1:0] discards;

  // stimulus view of the current settings
  logic [7:0] sync_a  = RST_SYNC_FIRST;
  logic [7:0] sync_b  = RST_SYNC_SECOND;
  logic [7:0] len_lo  = RST_MIN_LENGTH;
  logic [7:0] len_hi  = RST_MAX_LENGTH;
  logic [7:0] len_cap = RST_ACCEPT_LIMIT;
  bit         gaps_on   = 1'b1;
  bit         stalls_on = 1'b1;
  int         bytes_sent     = 0;
  int         settings_count = 0;
  int         cycle_count    = 0;

  sync_length_deframer u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .rx_byte_i       (rx_byte),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .payload_valid_o (payload_valid),
    .payload_byte_o  (payload_byte),
    .frame_last_o    (frame_last),
    .frame_length_o  (frame_length),
    .discard_total_o (discard_total)
  );

  deframer_monitor u_monitor (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .rx_byte_i       (rx_byte),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .payload_valid_i (payload_valid),
    .payload_byte_i  (payload_byte),
    .frame_last_i    (frame_last),
    .frame_length_i  (frame_length),
    .discard_total_i (discard_total),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .delivered_o     (delivered),
    .frames_o        (frames),
    .discards_o      (discards)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side back-pressure
  always @(posedge clk) begin
    if (stalls_on) out_ready <= ($urandom_range(99) >= IDLE_PCT);
    else out_ready <= 1'b1;
  end

  // One byte transaction, with an optional random gap ahead of it
  task automatic send_byte(input logic [7:0] b);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Stop sending and hold off until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] sf, input logic [7:0] ss,
                                input logic [7:0] mn, input logic [7:0] mx,
                                input logic [7:0] al);
    drain();
    write_reg(REG_SYNC_FIRST, sf);
    write_reg(REG_SYNC_SECOND, ss);
    write_reg(REG_MIN_LENGTH, mn);
    write_reg(REG_MAX_LENGTH, mx);
    write_reg(REG_ACCEPT_LIMIT, al);
    write_reg(REG_UNUSED, 8'($urandom_range(255)));
    cfg_we  <= 1'b0;
    sync_a  = sf;
    sync_b  = ss;
    len_lo  = mn;
    len_hi  = mx;
    len_cap = al;
    settings_count++;
  endtask

  // Random byte, leaning toward the sync values
  function automatic logic [7:0] stream_byte();
    int r;
    r = $urandom_range(99);
    if (r < 15) return sync_a;
    if (r < 25) return sync_b;
    return 8'($urandom_range(255));
  endfunction

  // Accepted length, mostly short; edges and the delivery cap now and then
  function automatic logic [7:0] pick_good_len();
    int r;
    int span;
    r    = $urandom_range(99);
    span = int'(len_hi) - int'(len_lo);
    if (span < 0) return 8'($urandom_range(255));
    if (r < 12) return len_lo;
    if (r < 14) return len_hi;
    if (r < 24 && len_cap >= len_lo && len_cap < len_hi) return len_cap + 8'(r & 1);
    if (r < 97) return len_lo + 8'($urandom_range(span < 10 ? span : 10));
    return len_lo + 8'($urandom_range(span));
  endfunction

  // Length outside the accepted window, where one exists
  function automatic logic [7:0] pick_bad_len();
    if (len_lo > len_hi) return 8'($urandom_range(255));
    if (len_lo != 8'd0 && (len_hi == 8'hFF || $urandom_range(1) == 0))
      return 8'($urandom_range(int'(len_lo) - 1));
    if (len_hi != 8'hFF) return 8'($urandom_range(255, int'(len_hi) + 1));
    return pick_good_len();
  endfunction

  task automatic send_frame(input logic [7:0] len);
    send_byte(sync_a);
    send_byte(sync_b);
    send_byte(len);
    for (int i = 0; i < int'(len); i++) send_byte(stream_byte());
  endtask

  // Mostly whole frames, then bad lengths, cut headers, noise and pauses
  task automatic run_traffic(input int n);
    int stop_at;
    int r;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 65) begin
        send_frame(pick_good_len());
      end else if (r < 75) begin
        send_byte(sync_a);
        send_byte(sync_b);
        send_byte(pick_bad_len());
      end else if (r < 80) begin
        send_byte(sync_a);
        send_byte(sync_a);
      end else if (r < 99) begin
        repeat ($urandom_range(4, 1)) send_byte(stream_byte());
      end else begin
        drain();
      end
    end
  endtask

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
    $display("sync_length_deframer: mismatch");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes as noise
    send_byte(8'h00);
    send_byte(8'hFF);
    // repeated first sync byte, then a minimum-length frame
    send_byte(sync_a);
    send_byte(sync_a);
    send_byte(sync_b);
    send_byte(8'd1);
    send_byte(8'hFF);
    // length below the minimum forces a rescan
    send_byte(sync_a);
    send_byte(sync_b);
    send_byte(8'd0);
    // sync pair carried inside a payload
    send_byte(sync_a);
    send_byte(sync_b);
    send_byte(8'd4);
    send_byte(sync_a);
    send_byte(sync_b);
    send_byte(8'd2);
    send_byte(8'h00);

    apply_settings(RST_SYNC_FIRST, RST_SYNC_SECOND, RST_MIN_LENGTH,
                   RST_MAX_LENGTH, RST_ACCEPT_LIMIT);
    run_traffic(250);
    // long stretch at full rate on both sides
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    run_traffic(300);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;

    // zero length is a complete frame
    apply_settings(8'h00, 8'hFF, 8'd0, 8'd255, 8'd255);
    send_frame(8'd0);
    run_traffic(250);
    // minimum above maximum: no length passes
    apply_settings(8'h3C, 8'hC3, 8'd10, 8'd3, 8'd255);
    run_traffic(150);
    // equal sync bytes with a narrow window and a low delivery cap
    apply_settings(8'h7E, 8'h7E, 8'd2, 8'd6, 8'd4);
    run_traffic(300);
    // nothing is delivered
    apply_settings(8'hFF, 8'h00, 8'd0, 8'd20, 8'd0);
    run_traffic(200);
    // only the longest frames pass
    apply_settings(8'h5A, 8'hA5, 8'd255, 8'd255, 8'd255);
    run_traffic(350);
    // only zero-length frames pass
    apply_settings(8'h81, 8'h18, 8'd0, 8'd0, 8'd255);
    run_traffic(150);

    drain();
    $display("%0d bytes under %0d register settings: %0d payload bytes in %0d frames,",
             bytes_sent, settings_count, delivered, frames);
    $display("%0d bytes discarded while hunting, %0d field errors", discards, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("sync_length_deframer: match");
    end else begin
      $display("sync_length_deframer: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sld_pkg.sv
rtl/sld_cfg_regs.sv
rtl/sld_frame_fsm.sv
rtl/sync_length_deframer.sv
rtl/sld_checker.sv
tb/deframer_monitor.sv
tb/sync_length_deframer_tb.sv
